[rtl/tfn_pkg.sv]
// Shared widths, constants and pipeline payload types of the triangle face normal block.
// Used by every module and interface of the block; depends on nothing.
package tfn_pkg;

  localparam int COORD_BITS       = 24;
  localparam int NORMAL_FRAC_BITS = 15;
  localparam int TARGET_BITS      = 31;
  localparam int OUT_W            = 16;

  localparam int EDGE_W  = COORD_BITS + 1;
  localparam int PROD_W  = 2 * EDGE_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int NORM_W  = (CROSS_W > TARGET_BITS) ? CROSS_W : TARGET_BITS;
  localparam int SHW     = $clog2(NORM_W);
  localparam int NSH     = SHW;
  localparam int M_W     = TARGET_BITS;
  localparam int SQ_W    = 2 * M_W + 2;
  localparam int ROOT_W  = M_W + 1;
  localparam int RBW     = $clog2(ROOT_W);
  localparam int QW      = NORMAL_FRAC_BITS + 1;
  localparam int QBW     = $clog2(QW);
  localparam int NUM_W   = M_W + NORMAL_FRAC_BITS + 1;
  localparam int DV_W    = ROOT_W + QW;
  localparam int LIM_I   = (((1 << NORMAL_FRAC_BITS) - 1) > 32767) ? 32767
                                                                 : ((1 << NORMAL_FRAC_BITS) - 1);

  typedef struct packed {
    logic [2:0][COORD_BITS-1:0] a;
    logic [2:0][COORD_BITS-1:0] b;
    logic [2:0][COORD_BITS-1:0] c;
  } tri_t;

  typedef struct packed {
    logic [2:0]             neg;
    logic                   degen;
    logic [2:0][NORM_W-1:0] mag;
  } norm_t;

  typedef struct packed {
    logic [2:0]            neg;
    logic                  degen;
    logic [2:0][M_W-1:0]   m;
    logic [SQ_W-1:0]       rem;
    logic [ROOT_W-1:0]     root;
  } sqrt_t;

  typedef struct packed {
    logic [2:0]            neg;
    logic                  degen;
    logic [ROOT_W-1:0]     len;
    logic [2:0][NUM_W-1:0] rem;
    logic [2:0][QW-1:0]    q;
  } div_t;

endpackage

[rtl/tfn_in_if.sv]
// Input channel: one triangle per transfer, valid/ready handshake.
// Depends on tfn_pkg for the coordinate width.
interface tfn_in_if;
  logic valid;
  logic ready;
  logic [tfn_pkg::COORD_BITS-1:0] a_x, a_y, a_z;
  logic [tfn_pkg::COORD_BITS-1:0] b_x, b_y, b_z;
  logic [tfn_pkg::COORD_BITS-1:0] c_x, c_y, c_z;

  modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, input ready);
  modport sink   (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, output ready);
endinterface

[rtl/tfn_out_if.sv]
// Output channel: one unit normal per transfer, valid/ready handshake.
// Depends on tfn_pkg for the output width.
interface tfn_out_if;
  logic valid;
  logic ready;
  logic [tfn_pkg::OUT_W-1:0] normal_x, normal_y, normal_z;
  logic degenerate;

  modport source (output valid, normal_x, normal_y, normal_z, degenerate, input ready);
  modport sink   (input valid, normal_x, normal_y, normal_z, degenerate, output ready);
endinterface

[rtl/tfn_cross.sv]
// Edge vectors and cross product, four pipeline stages, sign/magnitude result.
// Depends on tfn_pkg.
module tfn_cross (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  tfn_pkg::tri_t   data_i,
  output logic            valid_o,
  input  logic            ready_i,
  output tfn_pkg::norm_t  data_o
);

  function automatic logic signed [tfn_pkg::PROD_W-1:0] smul(
    logic [tfn_pkg::EDGE_W-1:0] x, logic [tfn_pkg::EDGE_W-1:0] y);
    logic signed [tfn_pkg::PROD_W-1:0] xs, ys;
    xs = tfn_pkg::PROD_W'($signed(x));
    ys = tfn_pkg::PROD_W'($signed(y));
    return xs * ys;
  endfunction

  logic [3:0] vld_q;
  logic [4:0] rdy;

  logic [2:0][tfn_pkg::EDGE_W-1:0]  e1_q, e2_q;
  logic [5:0][tfn_pkg::PROD_W-1:0]  prod_q;
  logic [2:0][tfn_pkg::CROSS_W-1:0] diff_q;
  tfn_pkg::norm_t                   out_q;

  logic [2:0][tfn_pkg::EDGE_W-1:0]  e1_d, e2_d;
  logic [5:0][tfn_pkg::PROD_W-1:0]  prod_d;
  logic [2:0][tfn_pkg::CROSS_W-1:0] diff_d;
  tfn_pkg::norm_t                   out_d;

  assign rdy[4] = ready_i;
  always_comb begin
    for (int k = 0; k < 4; k++) rdy[k] = !vld_q[k] || rdy[k+1];
  end
  assign ready_o = rdy[0];
  assign valid_o = vld_q[3];
  assign data_o  = out_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e1_d[i] = tfn_pkg::EDGE_W'($signed(data_i.b[i])) - tfn_pkg::EDGE_W'($signed(data_i.a[i]));
      e2_d[i] = tfn_pkg::EDGE_W'($signed(data_i.c[i])) - tfn_pkg::EDGE_W'($signed(data_i.a[i]));
    end
    prod_d[0] = smul(e1_q[1], e2_q[2]);
    prod_d[1] = smul(e1_q[2], e2_q[1]);
    prod_d[2] = smul(e1_q[2], e2_q[0]);
    prod_d[3] = smul(e1_q[0], e2_q[2]);
    prod_d[4] = smul(e1_q[0], e2_q[1]);
    prod_d[5] = smul(e1_q[1], e2_q[0]);
    for (int i = 0; i < 3; i++) begin
      diff_d[i] = tfn_pkg::CROSS_W'($signed(prod_q[2*i]))
                - tfn_pkg::CROSS_W'($signed(prod_q[2*i+1]));
    end
    for (int i = 0; i < 3; i++) begin
      out_d.neg[i] = diff_q[i][tfn_pkg::CROSS_W-1];
      out_d.mag[i] = tfn_pkg::NORM_W'(out_d.neg[i] ? (~diff_q[i] + 1'b1) : diff_q[i]);
    end
    out_d.degen = (diff_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) vld_q[0] <= valid_i;
      for (int k = 1; k < 4; k++) if (rdy[k]) vld_q[k] <= vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && valid_i) begin
      e1_q <= e1_d;
      e2_q <= e2_d;
    end
    if (rdy[1] && vld_q[0]) prod_q <= prod_d;
    if (rdy[2] && vld_q[1]) diff_q <= diff_d;
    if (rdy[3] && vld_q[2]) out_q  <= out_d;
  end

endmodule

[rtl/tfn_norm_cell.sv]
// One step of the normalizing shift: shifts all three magnitudes left by a
// fixed power of two when the top bits of their OR are clear. Depends on tfn_pkg.
module tfn_norm_cell (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [tfn_pkg::SHW-1:0] shift_i,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  tfn_pkg::norm_t          data_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output tfn_pkg::norm_t          data_o
);

  logic                       vld_q;
  tfn_pkg::norm_t             data_q, data_d;
  logic [tfn_pkg::NORM_W-1:0] orw, mask;
  logic                       hit;

  always_comb begin
    orw  = data_i.mag[0] | data_i.mag[1] | data_i.mag[2];
    mask = ~({tfn_pkg::NORM_W{1'b1}} >> shift_i);
    hit  = ((orw & mask) == '0);
    data_d = data_i;
    if (hit) begin
      for (int i = 0; i < 3; i++) data_d.mag[i] = data_i.mag[i] << shift_i;
    end
  end

  assign ready_o = !vld_q || ready_i;
  assign valid_o = vld_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) data_q <= data_d;
  end

endmodule

[rtl/tfn_square.sv]
// Takes the top bits of the normalized magnitudes, squares them and sums
// the squares; two stages. Depends on tfn_pkg.
module tfn_square (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  tfn_pkg::norm_t data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output tfn_pkg::sqrt_t data_o
);

  localparam int P_W = 2 * tfn_pkg::M_W;

  logic [1:0] vld_q;
  logic [2:0] rdy;

  logic [2:0]                   neg_q;
  logic                         degen_q;
  logic [2:0][tfn_pkg::M_W-1:0] m_q, m_d;
  logic [2:0][P_W-1:0]          sq_q, sq_d;
  tfn_pkg::sqrt_t               out_q, out_d;

  assign rdy[2]  = ready_i;
  assign rdy[1]  = !vld_q[1] || rdy[2];
  assign rdy[0]  = !vld_q[0] || rdy[1];
  assign ready_o = rdy[0];
  assign valid_o = vld_q[1];
  assign data_o  = out_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m_d[i]  = data_i.mag[i][tfn_pkg::NORM_W-1 -: tfn_pkg::M_W];
      sq_d[i] = P_W'(m_d[i]) * P_W'(m_d[i]);
    end
    out_d.neg   = neg_q;
    out_d.degen = degen_q;
    out_d.m     = m_q;
    out_d.rem   = tfn_pkg::SQ_W'(sq_q[0]) + tfn_pkg::SQ_W'(sq_q[1]) + tfn_pkg::SQ_W'(sq_q[2]);
    out_d.root  = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) vld_q[0] <= valid_i;
      if (rdy[1]) vld_q[1] <= vld_q[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && valid_i) begin
      neg_q   <= data_i.neg;
      degen_q <= data_i.degen;
      m_q     <= m_d;
      sq_q    <= sq_d;
    end
    if (rdy[1] && vld_q[0]) out_q <= out_d;
  end

endmodule

[rtl/tfn_sqrt_cell.sv]
// One result bit of the restoring integer square root: keeps n - root^2
// and sets the root bit when the trial fits. Depends on tfn_pkg.
module tfn_sqrt_cell (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [tfn_pkg::RBW-1:0] bit_i,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  tfn_pkg::sqrt_t          data_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output tfn_pkg::sqrt_t          data_o
);

  localparam int TW = tfn_pkg::SQ_W + 1;

  logic           vld_q;
  tfn_pkg::sqrt_t data_q, data_d;
  logic [TW-1:0]  trial;
  logic           fit;

  always_comb begin
    // (root + 2^i)^2 - root^2 = root * 2^(i+1) + 2^(2i)
    trial = (TW'(data_i.root) << ({1'b0, bit_i} + 1'b1)) + (TW'(1) << {bit_i, 1'b0});
    fit   = {1'b0, data_i.rem} >= trial;
    data_d = data_i;
    if (fit) begin
      data_d.rem  = data_i.rem - trial[tfn_pkg::SQ_W-1:0];
      data_d.root = data_i.root | (tfn_pkg::ROOT_W'(1) << bit_i);
    end
  end

  assign ready_o = !vld_q || ready_i;
  assign valid_o = vld_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) data_q <= data_d;
  end

endmodule

[rtl/tfn_div_cell.sv]
// One quotient bit of the restoring division, three lanes sharing the
// divisor (the vector length). Depends on tfn_pkg.
module tfn_div_cell (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [tfn_pkg::QBW-1:0] bit_i,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  tfn_pkg::div_t           data_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output tfn_pkg::div_t           data_o
);

  logic                     vld_q;
  tfn_pkg::div_t            data_q, data_d;
  logic [tfn_pkg::DV_W-1:0] dvs;

  always_comb begin
    dvs    = tfn_pkg::DV_W'(data_i.len) << bit_i;
    data_d = data_i;
    for (int i = 0; i < 3; i++) begin
      if (tfn_pkg::DV_W'(data_i.rem[i]) >= dvs) begin
        data_d.rem[i] = data_i.rem[i] - dvs[tfn_pkg::NUM_W-1:0];
        data_d.q[i]   = data_i.q[i] | (tfn_pkg::QW'(1) << bit_i);
      end
    end
  end

  assign ready_o = !vld_q || ready_i;
  assign valid_o = vld_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) data_q <= data_d;
  end

endmodule

[rtl/triangle_face_normal.sv]
// Top level of the triangle face normal block; depends on tfn_pkg, the two
// channel interfaces, tfn_cross, tfn_norm_cell, tfn_square, tfn_sqrt_cell, tfn_div_cell.
//
// One triangle in, one unit face normal out, one transfer per cycle unless stalled.
// The datapath is a single chain of pipeline cells with per-stage valid bits and
// a ready chain, so bubbles are squeezed out and a new triangle is taken while a
// finished normal waits in the output register. Each triangle passes through the
// edge and cross product stages, 6 normalize-shift cells (32,16,..,1), the square
// and sum stages, 32 square-root cells (one root bit each), 16 division cells
// (one quotient bit each, three lanes) and the output register. The square root
// and division chains set the latency; throughput is one triangle per clock
// while the output is ready. A zero cross product yields (0, 0, +max) with
// degenerate set. No state is kept between triangles.
module triangle_face_normal (
  input  logic      clk_i,
  input  logic      rst_ni,
  tfn_in_if.sink    tri_i,
  tfn_out_if.source nrm_o
);

  // ---- input payload ----
  tfn_pkg::tri_t tri_d;
  assign tri_d.a = {tri_i.a_z, tri_i.a_y, tri_i.a_x};
  assign tri_d.b = {tri_i.b_z, tri_i.b_y, tri_i.b_x};
  assign tri_d.c = {tri_i.c_z, tri_i.c_y, tri_i.c_x};

  // ---- normalize chain ----
  logic           nv [tfn_pkg::NSH+1];
  logic           nr [tfn_pkg::NSH+1];
  tfn_pkg::norm_t nd [tfn_pkg::NSH+1];

  tfn_cross u_cross (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (tri_i.valid),
    .ready_o (tri_i.ready),
    .data_i  (tri_d),
    .valid_o (nv[0]),
    .ready_i (nr[0]),
    .data_o  (nd[0])
  );

  for (genvar k = 0; k < tfn_pkg::NSH; k++) begin : g_norm
    tfn_norm_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (tfn_pkg::SHW'(1 << (tfn_pkg::NSH - 1 - k))),
      .valid_i (nv[k]),
      .ready_o (nr[k]),
      .data_i  (nd[k]),
      .valid_o (nv[k+1]),
      .ready_i (nr[k+1]),
      .data_o  (nd[k+1])
    );
  end

  // ---- square root chain ----
  logic           sv [tfn_pkg::ROOT_W+1];
  logic           sr [tfn_pkg::ROOT_W+1];
  tfn_pkg::sqrt_t sd [tfn_pkg::ROOT_W+1];

  tfn_square u_square (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (nv[tfn_pkg::NSH]),
    .ready_o (nr[tfn_pkg::NSH]),
    .data_i  (nd[tfn_pkg::NSH]),
    .valid_o (sv[0]),
    .ready_i (sr[0]),
    .data_o  (sd[0])
  );

  // root bits MSB first
  for (genvar k = 0; k < tfn_pkg::ROOT_W; k++) begin : g_sqrt
    tfn_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .bit_i   (tfn_pkg::RBW'(tfn_pkg::ROOT_W - 1 - k)),
      .valid_i (sv[k]),
      .ready_o (sr[k]),
      .data_i  (sd[k]),
      .valid_o (sv[k+1]),
      .ready_i (sr[k+1]),
      .data_o  (sd[k+1])
    );
  end

  // ---- division chain ----
  logic          dv [tfn_pkg::QW+1];
  logic          dr [tfn_pkg::QW+1];
  tfn_pkg::div_t dd [tfn_pkg::QW+1];

  // numerator = m * 2^F + floor(len / 2), rounds to nearest
  always_comb begin
    dd[0].neg   = sd[tfn_pkg::ROOT_W].neg;
    dd[0].degen = sd[tfn_pkg::ROOT_W].degen;
    dd[0].len   = sd[tfn_pkg::ROOT_W].root;
    for (int i = 0; i < 3; i++) begin
      dd[0].rem[i] = (tfn_pkg::NUM_W'(sd[tfn_pkg::ROOT_W].m[i]) << tfn_pkg::NORMAL_FRAC_BITS)
                   + tfn_pkg::NUM_W'(sd[tfn_pkg::ROOT_W].root >> 1);
      dd[0].q[i]   = '0;
    end
  end
  assign dv[0] = sv[tfn_pkg::ROOT_W];
  assign sr[tfn_pkg::ROOT_W] = dr[0];

  for (genvar k = 0; k < tfn_pkg::QW; k++) begin : g_div
    tfn_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .bit_i   (tfn_pkg::QBW'(tfn_pkg::QW - 1 - k)),
      .valid_i (dv[k]),
      .ready_o (dr[k]),
      .data_i  (dd[k]),
      .valid_o (dv[k+1]),
      .ready_i (dr[k+1]),
      .data_o  (dd[k+1])
    );
  end

  // ---- saturate, apply sign, output register ----
  localparam logic [tfn_pkg::QW-1:0]    LIM   = tfn_pkg::QW'(tfn_pkg::LIM_I);
  localparam logic [tfn_pkg::OUT_W-1:0] LIM_O = tfn_pkg::OUT_W'(tfn_pkg::LIM_I);

  logic                                out_vld_q;
  logic [2:0][tfn_pkg::OUT_W-1:0]      nrm_q, nrm_d;
  logic                                degen_q;
  logic [tfn_pkg::QW-1:0]              qs;
  logic [tfn_pkg::OUT_W-1:0]           qx;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qs       = (dd[tfn_pkg::QW].q[i] > LIM) ? LIM : dd[tfn_pkg::QW].q[i];
      qx       = tfn_pkg::OUT_W'(qs);
      nrm_d[i] = dd[tfn_pkg::QW].neg[i] ? (~qx + 1'b1) : qx;
    end
    if (dd[tfn_pkg::QW].degen) begin
      nrm_d[0] = '0;
      nrm_d[1] = '0;
      nrm_d[2] = LIM_O;
    end
  end

  assign dr[tfn_pkg::QW] = !out_vld_q || nrm_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (dr[tfn_pkg::QW]) begin
      out_vld_q <= dv[tfn_pkg::QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (dr[tfn_pkg::QW] && dv[tfn_pkg::QW]) begin
      nrm_q   <= nrm_d;
      degen_q <= dd[tfn_pkg::QW].degen;
    end
  end

  assign nrm_o.valid      = out_vld_q;
  assign nrm_o.normal_x   = nrm_q[0];
  assign nrm_o.normal_y   = nrm_q[1];
  assign nrm_o.normal_z   = nrm_q[2];
  assign nrm_o.degenerate = degen_q;

endmodule
